// ===== hw/rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache table package
// Sizes, beat types, the entry record and controller codes shared by the
// LFU cache table modules.
// ----------------------------------------------------------------------------
package lfu_pkg;

  // Table geometry.
  localparam int CAPACITY    = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CFG_W       = 5;

  // Slot index, and counters that must also hold CAPACITY itself.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Width used to compare occupancy against the effective capacity.
  localparam int EC_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  // Input beat.
  typedef struct packed {
    logic              mode;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] write_value;
  } lfu_in_t;

  // Result beat.
  typedef struct packed {
    logic              found;
    logic signed [VAL_W-1:0] read_value;
    logic              evicted;
  } lfu_out_t;

  // One stored entry. Rank 0 is the most recently touched entry.
  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [VAL_W-1:0]       value;
    logic [COUNT_WIDTH-1:0] count;
    logic [IDX_W-1:0]       rank;
  } lfu_entry_t;

  // Request from the controller to the entry memory.
  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    lfu_entry_t       wdata;
  } lfu_ram_req_t;

  // Operation codes.
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } lfu_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lfu_entry_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU entry memory
// One write port and one read port with registered read data; holds key,
// value, use count and recency rank of every slot.
// ----------------------------------------------------------------------------
module lfu_entry_ram (
  input  wire logic                 clk,
  input  wire lfu_pkg::lfu_ram_req_t req,
  output      lfu_pkg::lfu_entry_t   rd_data
);
  import lfu_pkg::*;

  lfu_entry_t mem [CAPACITY];
  lfu_entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rd_data = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lfu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache table controller
// Walks the entry memory once to find the hit and the eviction victim, then,
// unless a get misses, again to rewrite recency ranks and the target slot.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire lfu_pkg::lfu_in_t            in_data,
  output      logic                        out_valid,
  output      lfu_pkg::lfu_out_t           out_data,
  input  wire logic [lfu_pkg::EC_W-1:0]    eff_cap,
  output      lfu_pkg::lfu_ram_req_t       ram_req,
  input  wire lfu_pkg::lfu_entry_t         ram_rdata
);
  import lfu_pkg::*;

  // Control state.
  lfu_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     ctr_r, ctr_nxt;
  logic                 rv_r, rv_nxt;
  logic [CAPACITY-1:0]  valid_r, valid_nxt;
  logic [CNT_W-1:0]     held_r, held_nxt;

  // Operation payload and scan results.
  lfu_in_t              op_r, op_nxt;
  logic [IDX_W-1:0]     idx_d_r, idx_d_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]     hit_rank_r, hit_rank_nxt;
  logic [VAL_W-1:0]     hit_val_r, hit_val_nxt;
  logic                 vic_have_r, vic_have_nxt;
  logic [IDX_W-1:0]     vic_idx_r, vic_idx_nxt;
  logic [COUNT_WIDTH-1:0] vic_cnt_r, vic_cnt_nxt;
  logic [IDX_W-1:0]     vic_rank_r, vic_rank_nxt;
  logic [IDX_W-1:0]     tgt_r, tgt_nxt;
  logic [CNT_W-1:0]     thr_r, thr_nxt;
  logic                 ins_r, ins_nxt;
  logic                 found_r, found_nxt;
  logic [VAL_W-1:0]     rd_r, rd_nxt;
  logic                 ev_r, ev_nxt;

  logic                 rd_issue;
  logic                 cur_valid;
  logic [IDX_W-1:0]     free_idx;
  lfu_entry_t           wr_entry;

  // Lowest-numbered free slot.
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign cur_valid = valid_r[idx_d_r];

  // Next state, memory requests and scan bookkeeping.
  always_comb begin
    state_nxt    = state_r;
    ctr_nxt      = ctr_r;
    valid_nxt    = valid_r;
    held_nxt     = held_r;
    op_nxt       = op_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_rank_nxt = hit_rank_r;
    hit_val_nxt  = hit_val_r;
    vic_have_nxt = vic_have_r;
    vic_idx_nxt  = vic_idx_r;
    vic_cnt_nxt  = vic_cnt_r;
    vic_rank_nxt = vic_rank_r;
    tgt_nxt      = tgt_r;
    thr_nxt      = thr_r;
    ins_nxt      = ins_r;
    found_nxt    = found_r;
    rd_nxt       = rd_r;
    ev_nxt       = ev_r;
    out_valid    = 1'b0;
    wr_entry     = ram_rdata;

    // Both passes walk the slots in order, one read issued per cycle.
    rd_issue = ((state_r == ST_SCAN) || (state_r == ST_UPDATE)) &&
               (ctr_r < CNT_W'(CAPACITY));
    ram_req       = '0;
    ram_req.re    = rd_issue;
    ram_req.raddr = ctr_r[IDX_W-1:0];
    rv_nxt        = rd_issue;
    idx_d_nxt     = ctr_r[IDX_W-1:0];
    if (rd_issue) begin
      ctr_nxt = ctr_r + CNT_W'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt       = in_data;
          ctr_nxt      = '0;
          hit_nxt      = 1'b0;
          vic_have_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (rv_r && cur_valid) begin
          // First valid slot holding the key is the hit.
          if (!hit_r && (ram_rdata.key == op_r.lookup_key)) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = idx_d_r;
            hit_rank_nxt = ram_rdata.rank;
            hit_val_nxt  = ram_rdata.value;
          end
          // Victim: lowest count, ties go to the oldest entry.
          if (!vic_have_r || (ram_rdata.count < vic_cnt_r) ||
              ((ram_rdata.count == vic_cnt_r) && (ram_rdata.rank > vic_rank_r))) begin
            vic_have_nxt = 1'b1;
            vic_idx_nxt  = idx_d_r;
            vic_cnt_nxt  = ram_rdata.count;
            vic_rank_nxt = ram_rdata.rank;
          end
        end
        if (ctr_r == CNT_W'(CAPACITY)) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        ctr_nxt   = '0;
        found_nxt = hit_r;
        rd_nxt    = (hit_r && (op_r.mode == MODE_GET)) ? hit_val_r : '1;
        ev_nxt    = 1'b0;
        if (hit_r) begin
          // Touch: younger entries age by one.
          tgt_nxt   = hit_idx_r;
          thr_nxt   = CNT_W'(hit_rank_r);
          ins_nxt   = 1'b0;
          state_nxt = ST_UPDATE;
        end else if (op_r.mode == MODE_PUT) begin
          ins_nxt   = 1'b1;
          state_nxt = ST_UPDATE;
          if (EC_W'(held_r) >= eff_cap) begin
            // Replace the victim; entries younger than it age by one.
            tgt_nxt = vic_idx_r;
            thr_nxt = CNT_W'(vic_rank_r);
            ev_nxt  = 1'b1;
          end else begin
            // Fill a free slot; every valid entry ages by one.
            tgt_nxt             = free_idx;
            thr_nxt             = CNT_W'(CAPACITY);
            valid_nxt[free_idx] = 1'b1;
            held_nxt            = held_r + CNT_W'(1);
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_UPDATE: begin
        if (rv_r) begin
          if (idx_d_r == tgt_r) begin
            wr_entry.rank = '0;
            if (ins_r) begin
              wr_entry.key   = op_r.lookup_key;
              wr_entry.value = op_r.write_value;
              wr_entry.count = COUNT_WIDTH'(1);
            end else begin
              if (op_r.mode == MODE_PUT) begin
                wr_entry.value = op_r.write_value;
              end
              if (ram_rdata.count != '1) begin
                wr_entry.count = ram_rdata.count + COUNT_WIDTH'(1);
              end
            end
          end else if (cur_valid && (CNT_W'(ram_rdata.rank) < thr_r)) begin
            wr_entry.rank = ram_rdata.rank + IDX_W'(1);
          end
          ram_req.we    = 1'b1;
          ram_req.waddr = idx_d_r;
          ram_req.wdata = wr_entry;
        end
        if (ctr_r == CNT_W'(CAPACITY)) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ctr_r   <= '0;
      rv_r    <= 1'b0;
      valid_r <= '0;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
      rv_r    <= rv_nxt;
      valid_r <= valid_nxt;
      held_r  <= held_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_d_r    <= idx_d_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_rank_r <= hit_rank_nxt;
    hit_val_r  <= hit_val_nxt;
    vic_have_r <= vic_have_nxt;
    vic_idx_r  <= vic_idx_nxt;
    vic_cnt_r  <= vic_cnt_nxt;
    vic_rank_r <= vic_rank_nxt;
    tgt_r      <= tgt_nxt;
    thr_r      <= thr_nxt;
    ins_r      <= ins_nxt;
    found_r    <= found_nxt;
    rd_r       <= rd_nxt;
    ev_r       <= ev_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_data.found      = found_r;
  assign out_data.read_value = rd_r;
  assign out_data.evicted    = ev_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lfu_cache_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache table
// Key-value table with least-frequently-used replacement and oldest-first
// tie break, held in one synchronous entry memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start; the beat is taken at a rising edge
//   with start high and busy low. mode 0 is a get, mode 1 a put.
//   Result: out_valid is high for one cycle with out_data; it must be taken
//   in that cycle, since the table cannot be held off.
//   Configuration: cfg_data is written when cfg_valid and cfg_ready are both
//   high (cfg_ready is always high); write it only while busy is low.
//   A value of 0 acts as 1 and a value above the table size acts as the size.
// Sequence:
//   Each operation walks the memory through its single read port: one pass
//   to find the hit and the victim, a decision state, then for every
//   operation except a get miss a second read-modify-write pass, and a
//   done state that raises the strobe. No new beat is taken before busy falls.
// Reset: synchronous rst_n clears all valid bits, the occupancy and the
//   controller; the capacity register returns to 16.
// ----------------------------------------------------------------------------
module lfu_cache_table_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire lfu_pkg::lfu_in_t            in_data,
  output      logic                        out_valid,
  output      lfu_pkg::lfu_out_t           out_data,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [lfu_pkg::CFG_W-1:0]   cfg_data
);
  import lfu_pkg::*;

  logic [CFG_W-1:0] cfg_r;
  logic [EC_W-1:0]  cap_ext;
  logic [EC_W-1:0]  eff_cap;
  lfu_ram_req_t     ram_req;
  lfu_entry_t       ram_rdata;

  // Capacity register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_data;
    end
  end

  // Clamp the programmed capacity to the range 1 to CAPACITY.
  assign cap_ext = EC_W'(cfg_r);
  always_comb begin
    if (cfg_r == '0) begin
      eff_cap = EC_W'(1);
    end else if (cap_ext > EC_W'(CAPACITY)) begin
      eff_cap = EC_W'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
  end

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .eff_cap   (eff_cap),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  lfu_entry_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

  // The result strobe lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // An accepted beat makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a beat");

  // The result is delivered while the operation still holds the block.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result delivered while idle");

  // The read-modify-write pass never reads the slot it is writing.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("entry memory read and write to the same slot");

endmodule
`default_nettype wire

// ===== bench/tb_lfu_cache_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache table testbench
// Drives get and put beats into the cache table and checks every result beat
// against a shadow table with the same least-frequently-used replacement and
// oldest-first tie break. Directed tests cover the key extremes and the
// capacity corner cases. Random phases at several capacities follow, most
// with random sender gaps.
// ----------------------------------------------------------------------------
module tb_lfu_cache_table_top;
  import lfu_pkg::*;

  localparam int RUN_LIMIT     = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int POOL_MAX      = 32;
  localparam int REPORT_MAX    = 10;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  lfu_in_t          in_data;
  logic             out_valid;
  lfu_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  lfu_cache_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock, 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Shadow copy of the table contents and the capacity register.
  logic                   sh_valid [CAPACITY];
  logic [KEY_W-1:0]       sh_key   [CAPACITY];
  logic [VAL_W-1:0]       sh_value [CAPACITY];
  logic [COUNT_WIDTH-1:0] sh_count [CAPACITY];
  int unsigned            sh_rank  [CAPACITY];
  int unsigned            sh_held;
  logic [CFG_W-1:0]       sh_capacity;

  // Results predicted for accepted beats, oldest first.
  lfu_out_t    due_results[$];
  lfu_out_t    want_result;
  int unsigned mismatches;
  int unsigned cycle_count;

  // Key pool for the random phases, so that hits and evictions are common.
  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int unsigned      pool_used;
  bit               idle_on;

  function automatic void shadow_reset();
    for (int i = 0; i < CAPACITY; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i]   = '0;
      sh_value[i] = '0;
      sh_count[i] = '0;
      sh_rank[i]  = 0;
    end
    sh_held     = 0;
    sh_capacity = CFG_RESET;
  endfunction

  // A register value of zero acts as one; values above the table size clamp.
  function automatic int unsigned capacity_limit();
    if (sh_capacity == 0) return 1;
    if (sh_capacity > CAPACITY) return CAPACITY;
    return sh_capacity;
  endfunction

  // Make a slot the most recent one and bump its use count, saturating.
  function automatic void touch_slot(int unsigned s);
    int unsigned r;
    r = sh_rank[s];
    for (int i = 0; i < CAPACITY; i++) begin
      if (sh_valid[i] && sh_rank[i] < r) sh_rank[i]++;
    end
    sh_rank[s] = 0;
    if (sh_count[s] != {COUNT_WIDTH{1'b1}}) sh_count[s]++;
  endfunction

  // Apply one operation to the shadow table and return its result beat.
  function automatic lfu_out_t table_predict(lfu_in_t op);
    lfu_out_t    res;
    int unsigned hit;
    int unsigned slot;
    int unsigned r;
    bit          have;
    res.found      = 1'b0;
    res.read_value = '1;
    res.evicted    = 1'b0;
    hit            = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sh_valid[i] && sh_key[i] == op.lookup_key) begin
        hit       = i;
        res.found = 1'b1;
        break;
      end
    end
    if (res.found) begin
      if (op.mode == MODE_PUT) sh_value[hit] = op.write_value;
      else res.read_value = sh_value[hit];
      touch_slot(hit);
    end else if (op.mode == MODE_PUT) begin
      slot = 0;
      have = 1'b0;
      // Full table: the victim has the lowest count, the oldest among ties.
      if (sh_held >= capacity_limit()) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (sh_valid[i] && (!have || sh_count[i] < sh_count[slot] ||
              (sh_count[i] == sh_count[slot] && sh_rank[i] > sh_rank[slot]))) begin
            slot = i;
            have = 1'b1;
          end
        end
        if (have) begin
          r              = sh_rank[slot];
          sh_valid[slot] = 1'b0;
          for (int i = 0; i < CAPACITY; i++) begin
            if (sh_valid[i] && sh_rank[i] > r) sh_rank[i]--;
          end
          sh_held--;
          res.evicted = 1'b1;
        end
      end
      if (!res.evicted) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (!sh_valid[i]) begin
            slot = i;
            break;
          end
        end
      end
      // The new entry goes in as the most recent one with a count of one.
      for (int i = 0; i < CAPACITY; i++) begin
        if (sh_valid[i]) sh_rank[i]++;
      end
      sh_valid[slot] = 1'b1;
      sh_key[slot]   = op.lookup_key;
      sh_value[slot] = op.write_value;
      sh_count[slot] = COUNT_WIDTH'(1);
      sh_rank[slot]  = 0;
      sh_held++;
    end
    return res;
  endfunction

  function automatic lfu_in_t make_op(logic mode, logic [KEY_W-1:0] key,
                                      logic [VAL_W-1:0] value);
    lfu_in_t op;
    op.mode        = mode;
    op.lookup_key  = key;
    op.write_value = value;
    return op;
  endfunction

  function automatic logic [KEY_W-1:0] extreme_word();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Mostly puts and gets on pooled keys, with some fresh random keys.
  function automatic lfu_in_t random_op();
    lfu_in_t op;
    op.mode = ($urandom_range(0, 99) < 55) ? MODE_PUT : MODE_GET;
    if ($urandom_range(0, 99) < 85) op.lookup_key = key_pool[$urandom_range(0, pool_used - 1)];
    else op.lookup_key = $urandom;
    op.write_value = ($urandom_range(0, 19) == 0) ? extreme_word() : $urandom;
    return op;
  endfunction

  // Sender gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  function automatic void refill_pool();
    for (int i = 0; i < POOL_MAX; i++) begin
      key_pool[i] = ($urandom_range(0, 9) == 0) ? extreme_word() : $urandom;
    end
    pool_used = capacity_limit() + $urandom_range(1, 8);
    if (pool_used > POOL_MAX) pool_used = POOL_MAX;
  endfunction

  // Send one beat, record its prediction once taken, then idle for a while.
  task automatic send_op(input lfu_in_t op);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    @(negedge clk);
    in_data <= op;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    due_results.push_back(table_predict(op));
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (due_results.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sh_capacity = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Key and value extremes at the reset capacity, hits and updates.
  task automatic test_extreme_keys();
    send_op(make_op(MODE_GET, 32'h8000_0000, 32'h1234_5678));
    send_op(make_op(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
    send_op(make_op(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
    send_op(make_op(MODE_PUT, 32'h0000_0000, 32'h0000_0000));
    send_op(make_op(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_op(make_op(MODE_GET, 32'h8000_0000, 32'h0000_0000));
    send_op(make_op(MODE_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_op(make_op(MODE_GET, 32'h0000_0000, 32'h0000_0000));
    send_op(make_op(MODE_PUT, 32'h7FFF_FFFF, 32'h5A5A_A5A5));
    send_op(make_op(MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000));
  endtask

  // A zero capacity acts as one and lies below the current occupancy, so
  // each put miss evicts exactly one entry before it inserts.
  task automatic test_shrunk_capacity();
    write_capacity(5'd0);
    send_op(make_op(MODE_PUT, 32'h0000_0005, 32'hCAFE_0005));
    send_op(make_op(MODE_PUT, 32'h0000_0006, 32'hCAFE_0006));
    send_op(make_op(MODE_GET, 32'h0000_0005, 32'h0000_0000));
    send_op(make_op(MODE_GET, 32'h0000_0006, 32'h0000_0000));
  endtask

  // Raised counts protect an entry; equal counts lose the oldest entry.
  task automatic test_lfu_tie_break();
    write_capacity(5'd3);
    send_op(make_op(MODE_GET, 32'h0000_0006, 32'h0000_0000));
    send_op(make_op(MODE_PUT, 32'h0000_0007, 32'hBEEF_0007));
    send_op(make_op(MODE_PUT, 32'h0000_0008, 32'hBEEF_0008));
    send_op(make_op(MODE_GET, 32'h0000_0007, 32'h0000_0000));
  endtask

  // A capacity above the table size acts as the table size.
  task automatic test_oversized_capacity();
    write_capacity(5'd31);
    send_op(make_op(MODE_PUT, 32'h0000_0009, 32'h0BAD_F00D));
    send_op(make_op(MODE_GET, 32'hDEAD_0000, 32'h0000_0000));
  endtask

  // Random traffic with one full pause of the sender in the middle.
  task automatic test_drain_pause();
    write_capacity(5'd6);
    refill_pool();
    idle_on = 1'b1;
    repeat (40) send_op(random_op());
    drain_results();
    repeat (40) send_op(random_op());
  endtask

  // Random phases across several capacities, some without sender gaps.
  task automatic test_random_phases();
    logic [CFG_W-1:0] caps [9];
    caps = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd2, 5'd9, 5'd0, 5'd16};
    caps[7] = CFG_W'($urandom_range(0, 31));
    for (int p = 0; p < 9; p++) begin
      write_capacity(caps[p]);
      refill_pool();
      idle_on = (p % 3 != 2);
      repeat (90) send_op(random_op());
    end
  endtask

  // Result checker: every strobed beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: found=%0b read_value=%h evicted=%0b",
                   out_data.found, out_data.read_value, out_data.evicted);
      end else begin
        want_result = due_results.pop_front();
        if (out_data.found !== want_result.found ||
            out_data.read_value !== want_result.read_value ||
            out_data.evicted !== want_result.evicted) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: expected found=%0b read_value=%h evicted=%0b, got %0b %h %0b",
                     want_result.found, want_result.read_value, want_result.evicted,
                     out_data.found, out_data.read_value, out_data.evicted);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    mismatches  = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    pool_used   = 1;
    shadow_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extreme_keys();
    test_shrunk_capacity();
    test_lfu_tie_break();
    test_oversized_capacity();
    test_drain_pause();
    test_random_phases();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
